// ===== src/tdl_pkg.sv =====
package tdl_pkg;

    localparam int NODE_W          = 11;
    localparam int DIST_W          = 10;
    localparam int CNT_W           = 11;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        B_CLR,
        B_ROOT,
        B_POP,
        B_POPW,
        B_UDEP,
        B_EREAD,
        B_EDGE,
        B_VIS,
        L_RD1,
        L_RD2,
        L_WR,
        Q_START,
        Q_A,
        Q_B,
        Q_UP,
        Q_UPW,
        Q_EQ,
        Q_AN,
        Q_AN2,
        Q_AN3,
        Q_PAR,
        Q_PARW,
        Q_LD,
        S_DONE
    } t_state;

endpackage

// ===== src/tree_distance_binary_lifting_unit.sv =====
// Query: ends early when a node is out of range or unreached, else lifts the deeper node to equal
// depth and then both nodes toward the common ancestor, set by one registered ancestor read per step.
// Edge load: stores the edge, no result. Build: clears the tables, visits each reached node and scans
// the stored edges for new nodes, then fills each extra ancestor level for every node.
// One item is worked at a time; the next is taken once the result sits in the output register.
// Reset (synchronous, active low) clears control state; queries before the first build answer 0.
module tree_distance_binary_lifting_unit #(
    parameter int MAX_NODES   = tdl_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = tdl_pkg::LIFT_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tdl_pkg::S_TDATA_W-1:0] i_s_tdata,   // node_a, node_b, zero pad
    input  logic [1:0]                    i_s_tuser,   // cmd
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tdl_pkg::M_TDATA_W-1:0] o_m_tdata,   // common_ancestor, distance, zero pad
    output logic                          o_m_tuser,   // kind
    input  logic                          i_cfg_wr_en,
    input  logic [tdl_pkg::CNT_W-1:0]     i_cfg_wr_data
);

    localparam int NW  = tdl_pkg::NODE_W;
    localparam int AW  = $clog2(MAX_NODES + 1);
    localparam int DW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_NODES);
    localparam int SW  = $clog2(MAX_NODES);
    localparam int IW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int CW  = ((DW > LIFT_LEVELS) ? DW : LIFT_LEVELS) + 1;
    localparam int XW  = ((DW + 1) > tdl_pkg::DIST_W) ? (DW + 1) : tdl_pkg::DIST_W;
    localparam int PADW = tdl_pkg::M_TDATA_W - NW - tdl_pkg::DIST_W;

    tdl_pkg::t_state r_state, n_state;

    logic [tdl_pkg::CNT_W-1:0] r_node_count;
    logic [EW-1:0]             r_edge_cnt;
    logic                      r_built;
    logic [AW-1:0]             r_sp;
    logic                      r_ovalid;

    logic [AW-1:0] n_eff;
    logic [NW-1:0] in_a, in_b;
    tdl_pkg::t_cmd in_cmd;
    logic          s_acc;

    // Working registers.
    logic [AW-1:0] r_j, r_u, r_x, r_y, r_ax, r_lca;
    logic [NW-1:0] r_qa, r_qb;
    logic [EW-1:0] r_e;
    logic [IW-1:0] r_lvl, r_i;
    logic [DW-1:0] r_udep, r_da, r_db, r_dy, r_diff;
    logic          r_va;
    logic [AW-1:0] r_v;
    logic          r_res_kind;
    logic [NW-1:0] r_res_lca;
    logic [tdl_pkg::DIST_W-1:0] r_res_dist;
    logic [NW-1:0] r_out_lca;
    logic [tdl_pkg::DIST_W-1:0] r_out_dist;
    logic          r_out_kind;

    // Memories.
    logic [2*NW-1:0] edge_mem [MAX_NODES-1];
    logic            vis_mem  [MAX_NODES+1];
    logic [DW-1:0]   dep_mem  [MAX_NODES+1];
    logic [AW-1:0]   stk_mem  [MAX_NODES];
    logic [AW-1:0]   anc_mem  [2**(IW+AW)];

    logic [2*NW-1:0] edge_q;
    logic            vis_q;
    logic [DW-1:0]   dep_q;
    logic [AW-1:0]   stk_q;
    logic [AW-1:0]   anc_q;

    logic            edge_we;
    logic [EW-1:0]   edge_ra;
    logic            vis_we, vis_wd;
    logic [AW-1:0]   vis_wa, vis_ra;
    logic            dep_we;
    logic [AW-1:0]   dep_wa, dep_ra;
    logic [DW-1:0]   dep_wd;
    logic            stk_we;
    logic [SW-1:0]   stk_wa, stk_ra;
    logic [AW-1:0]   stk_wd;
    logic            anc_we;
    logic [IW+AW-1:0] anc_wa, anc_ra;
    logic [AW-1:0]   anc_wd;

    // Edge scan decode.
    logic [NW-1:0] ep, eq;
    logic          e_hit;
    logic [AW-1:0] e_v;
    logic          e_last;
    logic          q_lift;
    logic [XW-1:0] dist_full;

    function automatic logic node_ok(input logic [NW-1:0] nd, input logic [AW-1:0] lim);
        return (nd != '0) && (int'(nd) <= int'(lim));
    endfunction

    assign in_a   = i_s_tdata[NW-1:0];
    assign in_b   = i_s_tdata[2*NW-1:NW];
    assign in_cmd = tdl_pkg::t_cmd'(i_s_tuser);
    assign o_s_tready = (r_state == tdl_pkg::S_IDLE);
    assign s_acc  = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = AW'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            n_eff = AW'(MAX_NODES);
        end else begin
            n_eff = AW'(r_node_count);
        end
    end

    assign ep     = edge_q[NW-1:0];
    assign eq     = edge_q[2*NW-1:NW];
    assign e_hit  = node_ok(ep, n_eff) && node_ok(eq, n_eff)
                    && ((AW'(ep) == r_u) || (AW'(eq) == r_u));
    assign e_v    = (AW'(ep) == r_u) ? AW'(eq) : AW'(ep);
    assign e_last = (EW'(r_e + 1'b1) == r_edge_cnt) || (r_e == EW'(MAX_NODES - 2));
    assign q_lift = CW'(r_diff) >= (CW'(1) << r_i);
    assign dist_full = XW'(r_da) + XW'(r_db) - (XW'(dep_q) << 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdl_pkg::S_IDLE: begin
                if (s_acc && in_cmd == tdl_pkg::CMD_BUILD) begin
                    n_state = tdl_pkg::B_CLR;
                end else if (s_acc && in_cmd == tdl_pkg::CMD_QUERY) begin
                    n_state = tdl_pkg::Q_START;
                end
            end
            tdl_pkg::B_CLR: begin
                if (r_j == AW'(MAX_NODES)) n_state = tdl_pkg::B_ROOT;
            end
            tdl_pkg::B_ROOT: n_state = tdl_pkg::B_POP;
            tdl_pkg::B_POP: begin
                if (r_sp != '0) begin
                    n_state = tdl_pkg::B_POPW;
                end else if (LIFT_LEVELS > 1) begin
                    n_state = tdl_pkg::L_RD1;
                end else begin
                    n_state = tdl_pkg::S_DONE;
                end
            end
            tdl_pkg::B_POPW: n_state = tdl_pkg::B_UDEP;
            tdl_pkg::B_UDEP: begin
                n_state = (r_edge_cnt == '0) ? tdl_pkg::B_POP : tdl_pkg::B_EREAD;
            end
            tdl_pkg::B_EREAD: n_state = tdl_pkg::B_EDGE;
            tdl_pkg::B_EDGE: begin
                if (e_hit) begin
                    n_state = tdl_pkg::B_VIS;
                end else begin
                    n_state = e_last ? tdl_pkg::B_POP : tdl_pkg::B_EREAD;
                end
            end
            tdl_pkg::B_VIS: n_state = e_last ? tdl_pkg::B_POP : tdl_pkg::B_EREAD;
            tdl_pkg::L_RD1: n_state = tdl_pkg::L_RD2;
            tdl_pkg::L_RD2: n_state = tdl_pkg::L_WR;
            tdl_pkg::L_WR: begin
                if (r_j == AW'(MAX_NODES) && r_lvl == IW'(LIFT_LEVELS - 1)) begin
                    n_state = tdl_pkg::S_DONE;
                end else begin
                    n_state = tdl_pkg::L_RD1;
                end
            end
            tdl_pkg::Q_START: begin
                if (!r_built || !node_ok(r_qa, n_eff) || !node_ok(r_qb, n_eff)) begin
                    n_state = tdl_pkg::S_DONE;
                end else begin
                    n_state = tdl_pkg::Q_A;
                end
            end
            tdl_pkg::Q_A: n_state = tdl_pkg::Q_B;
            tdl_pkg::Q_B: n_state = (r_va && vis_q) ? tdl_pkg::Q_UP : tdl_pkg::S_DONE;
            tdl_pkg::Q_UP: begin
                if (q_lift) begin
                    n_state = tdl_pkg::Q_UPW;
                end else if (r_i == '0) begin
                    n_state = tdl_pkg::Q_EQ;
                end
            end
            tdl_pkg::Q_UPW: n_state = (r_i == '0) ? tdl_pkg::Q_EQ : tdl_pkg::Q_UP;
            tdl_pkg::Q_EQ:  n_state = (r_x == r_y) ? tdl_pkg::S_DONE : tdl_pkg::Q_AN;
            tdl_pkg::Q_AN:  n_state = tdl_pkg::Q_AN2;
            tdl_pkg::Q_AN2: n_state = tdl_pkg::Q_AN3;
            tdl_pkg::Q_AN3: n_state = (r_i == '0) ? tdl_pkg::Q_PAR : tdl_pkg::Q_AN;
            tdl_pkg::Q_PAR: n_state = tdl_pkg::Q_PARW;
            tdl_pkg::Q_PARW: n_state = tdl_pkg::Q_LD;
            tdl_pkg::Q_LD:  n_state = tdl_pkg::S_DONE;
            tdl_pkg::S_DONE: begin
                if (!r_ovalid || i_m_tready) n_state = tdl_pkg::S_IDLE;
            end
            default: n_state = tdl_pkg::S_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        edge_we = 1'b0;
        edge_ra = r_e;
        vis_we  = 1'b0;
        vis_wa  = r_j;
        vis_wd  = 1'b0;
        vis_ra  = AW'(r_qa);
        dep_we  = 1'b0;
        dep_wa  = e_v;
        dep_wd  = DW'(r_udep + 1'b1);
        dep_ra  = AW'(r_qa);
        stk_we  = 1'b0;
        stk_wa  = SW'(r_sp);
        stk_wd  = r_v;
        stk_ra  = SW'(r_sp - 1'b1);
        anc_we  = 1'b0;
        anc_wa  = {IW'(0), r_j};
        anc_wd  = '0;
        anc_ra  = {r_i, r_x};
        unique case (r_state)
            tdl_pkg::S_IDLE: begin
                edge_we = s_acc && (in_cmd == tdl_pkg::CMD_EDGE)
                          && (r_edge_cnt != EW'(MAX_NODES - 1));
            end
            tdl_pkg::B_CLR: begin
                vis_we = 1'b1;
                anc_we = 1'b1;
            end
            tdl_pkg::B_ROOT: begin
                vis_we = 1'b1;
                vis_wa = AW'(1);
                vis_wd = 1'b1;
                dep_we = 1'b1;
                dep_wa = AW'(1);
                dep_wd = '0;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = AW'(1);
            end
            tdl_pkg::B_POPW: dep_ra = stk_q;
            tdl_pkg::B_EDGE: vis_ra = e_v;
            tdl_pkg::B_VIS: begin
                vis_we = !vis_q;
                vis_wa = r_v;
                vis_wd = 1'b1;
                dep_we = !vis_q;
                dep_wa = r_v;
                stk_we = !vis_q && (int'(r_sp) < MAX_NODES);
                anc_we = !vis_q;
                anc_wa = {IW'(0), r_v};
                anc_wd = r_u;
            end
            tdl_pkg::L_RD1: anc_ra = {IW'(r_lvl - 1'b1), r_j};
            tdl_pkg::L_RD2: anc_ra = {IW'(r_lvl - 1'b1), anc_q};
            tdl_pkg::L_WR: begin
                anc_we = 1'b1;
                anc_wa = {r_lvl, r_j};
                anc_wd = anc_q;
            end
            tdl_pkg::Q_A: begin
                vis_ra = AW'(r_qb);
                dep_ra = AW'(r_qb);
            end
            tdl_pkg::Q_AN2: anc_ra = {r_i, r_y};
            tdl_pkg::Q_PAR: anc_ra = {IW'(0), r_x};
            tdl_pkg::Q_PARW: dep_ra = anc_q;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) edge_mem[r_edge_cnt] <= {in_b, in_a};
        edge_q <= edge_mem[edge_ra];
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_q <= vis_mem[vis_ra];
        if (dep_we) dep_mem[dep_wa] <= dep_wd;
        dep_q <= dep_mem[dep_ra];
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[stk_ra];
        if (anc_we) anc_mem[anc_wa] <= anc_wd;
        anc_q <= anc_mem[anc_ra];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tdl_pkg::S_IDLE;
            r_node_count <= tdl_pkg::CNT_W'(1);
            r_edge_cnt   <= '0;
            r_built      <= 1'b0;
            r_sp         <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_node_count <= i_cfg_wr_data;
            if (edge_we) r_edge_cnt <= EW'(r_edge_cnt + 1'b1);
            if (r_state == tdl_pkg::B_CLR) r_built <= 1'b1;
            if (r_state == tdl_pkg::B_ROOT) begin
                r_sp <= AW'(1);
            end else if (r_state == tdl_pkg::B_POP && r_sp != '0) begin
                r_sp <= AW'(r_sp - 1'b1);
            end else if (stk_we && r_state == tdl_pkg::B_VIS) begin
                r_sp <= AW'(r_sp + 1'b1);
            end
            if (r_state == tdl_pkg::S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tdl_pkg::S_IDLE: begin
                r_qa       <= in_a;
                r_qb       <= in_b;
                r_j        <= '0;
                r_lvl      <= IW'(1);
                r_res_kind <= (in_cmd == tdl_pkg::CMD_QUERY) ? tdl_pkg::KIND_QUERY
                                                              : tdl_pkg::KIND_BUILD;
                r_res_lca  <= '0;
                r_res_dist <= '0;
            end
            tdl_pkg::B_CLR:  r_j <= AW'(r_j + 1'b1);
            tdl_pkg::B_POP:  r_j <= '0;
            tdl_pkg::B_POPW: r_u <= stk_q;
            tdl_pkg::B_UDEP: begin
                r_udep <= dep_q;
                r_e    <= '0;
            end
            tdl_pkg::B_EDGE: begin
                r_v <= e_v;
                if (!e_hit) r_e <= EW'(r_e + 1'b1);
            end
            tdl_pkg::B_VIS: r_e <= EW'(r_e + 1'b1);
            tdl_pkg::L_WR: begin
                if (r_j == AW'(MAX_NODES)) begin
                    r_j   <= '0;
                    r_lvl <= IW'(r_lvl + 1'b1);
                end else begin
                    r_j <= AW'(r_j + 1'b1);
                end
            end
            tdl_pkg::Q_A: begin
                r_va <= vis_q;
                r_da <= dep_q;
            end
            tdl_pkg::Q_B: begin
                r_db <= dep_q;
                r_i  <= IW'(LIFT_LEVELS - 1);
                if (r_da < dep_q) begin
                    r_x    <= AW'(r_qb);
                    r_y    <= AW'(r_qa);
                    r_dy   <= r_da;
                    r_diff <= DW'(dep_q - r_da);
                end else begin
                    r_x    <= AW'(r_qa);
                    r_y    <= AW'(r_qb);
                    r_dy   <= dep_q;
                    r_diff <= DW'(r_da - dep_q);
                end
            end
            tdl_pkg::Q_UP: begin
                if (q_lift) begin
                    r_diff <= DW'(CW'(r_diff) - (CW'(1) << r_i));
                end else if (r_i != '0) begin
                    r_i <= IW'(r_i - 1'b1);
                end
            end
            tdl_pkg::Q_UPW: begin
                r_x <= anc_q;
                if (r_i != '0) r_i <= IW'(r_i - 1'b1);
            end
            tdl_pkg::Q_EQ: begin
                r_i <= IW'(LIFT_LEVELS - 1);
                if (r_x == r_y) begin
                    r_res_lca  <= NW'(r_x);
                    r_res_dist <= tdl_pkg::DIST_W'(XW'(r_da) + XW'(r_db) - (XW'(r_dy) << 1));
                end
            end
            tdl_pkg::Q_AN2: r_ax <= anc_q;
            tdl_pkg::Q_AN3: begin
                if (r_ax != anc_q) begin
                    r_x <= r_ax;
                    r_y <= anc_q;
                end
                if (r_i != '0) r_i <= IW'(r_i - 1'b1);
            end
            tdl_pkg::Q_PARW: r_lca <= anc_q;
            tdl_pkg::Q_LD: begin
                r_res_lca  <= NW'(r_lca);
                r_res_dist <= tdl_pkg::DIST_W'(dist_full);
            end
            default: ;
        endcase
        if (r_state == tdl_pkg::S_DONE && (!r_ovalid || i_m_tready)) begin
            r_out_kind <= r_res_kind;
            r_out_lca  <= r_res_lca;
            r_out_dist <= r_res_dist;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{PADW{1'b0}}, r_out_dist, r_out_lca};

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sp) <= MAX_NODES)
        else $error("stack pointer beyond capacity");

    a_edge_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdl_pkg::B_EDGE) |-> (r_e < r_edge_cnt))
        else $error("edge scan past stored edges");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == tdl_pkg::S_DONE))
        else $error("result raised outside done state");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdl_pkg::Q_START) |-> (r_res_kind == tdl_pkg::KIND_QUERY))
        else $error("query running with build result kind");

endmodule
